@@ hdl/fhss_pkg.sv @@
package fhss_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int STEP_DIVISOR_DEF = 198;

   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;
   localparam logic [24:0] WORD_MAX = 25'h1FFFFFF;

   localparam logic [1:0] CSR_HOP_SEED = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] CSR_BAND_START = 2'd2;
   localparam logic [1:0] CSR_BAND_END = 2'd3;

   typedef enum logic [1:0] {
      REQ_REBUILD = 2'd0,
      REQ_NEXT = 2'd1,
      REQ_READ = 2'd2,
      REQ_SET = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] slot_index;
   } req_item_type;

   typedef struct packed {
      logic [24:0] freq_word;
      logic [7:0] channel_number;
      logic [7:0] hop_position;
   } rsp_item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SP_DIV,
      ST_FILL,
      ST_SH_POS,
      ST_SH_MODST,
      ST_SH_MOD,
      ST_SH_RDI,
      ST_SH_RDJ,
      ST_SH_WRI,
      ST_SH_WRJ,
      ST_IX_MOD,
      ST_RD,
      ST_RDW,
      ST_MUL,
      ST_HZ,
      ST_WST,
      ST_WDIV,
      ST_WFIX
   } state_type;

endpackage

@@ hdl/fhss_hop_sequence_generator.sv @@
// read and set: slot index modulo table length, table read, then hop math to the result
// next: pointer advance, table read, hop math; one item at a time, next start taken
// in the cycle the result is shown; rebuild: spacing divide, table fill, shuffle of
// each non-first slot of a group, then hop math to the result; busy high for the whole item
// the result strobe lasts one cycle and cannot be stalled
// synchronous reset clears control state and loads the register defaults; table undefined
module fhss_hop_sequence_generator import fhss_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int STEP_DIVISOR = STEP_DIVISOR_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = AW + 1;
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(STEP_DIVISOR));

   logic [31:0] seed_ff, count_ff32, start_hz_ff, end_hz_ff;
   logic [7:0]  count_ff;
   state_type   state_ff, state_in;
   logic [LW-1:0] pos_ff, pos_in, base_ff, base_in, len_ff, len_in;
   logic [7:0]  m_ff, m_in, ch_ff, ch_in, ti_ff, ti_in;
   logic [AW-1:0] ptr_ff, ptr_in, addr_ff, addr_in;
   logic [31:0] rng_ff, rng_in, hz_ff, hz_in;
   logic [39:0] spacing_ff, spacing_in;
   logic [47:0] prod_ff, prod_in;
   logic [31:0] q_ff, q_in, r_ff, r_in;
   logic [1:0]  req_ff, req_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [7:0]  fc, sync, m_next;
   logic [31:0] diff;
   logic [40:0] sum;
   logic [63:0] qprod;
   logic [47:0] dprod;
   logic [31:0] qfix;
   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]  ram_wdata, ram_rdata;
   logic        wstart, wdone, nstart, ndone;
   logic [39:0] wdividend, wquo;
   logic [15:0] wdivisor, wrem, ndividend, ndivisor, nrem;
   logic [39:0] nquo_unused_w;
   logic [15:0] nquo;

   assign count_ff32 = {24'd0, count_ff};
   assign fc = (count_ff < 8'd2) ? 8'd2 : count_ff;
   assign sync = fc >> 1;
   assign diff = (end_hz_ff >= start_hz_ff) ? (end_hz_ff - start_hz_ff) : 32'd0;
   assign m_next = (m_ff + 8'd1 == fc) ? 8'd0 : m_ff + 8'd1;
   assign sum = {9'd0, start_hz_ff} + {1'b0, prod_ff[47:8]};
   assign nquo_unused_w = {24'd0, nquo};

   // word = hz / STEP_DIVISOR by reciprocal estimate and one correction
   assign qprod = 64'(hz_ff) * 64'(RECIP[31:0]);
   assign dprod = 48'(q_ff) * 48'(STEP_DIVISOR);
   assign qfix = (r_ff >= 32'(STEP_DIVISOR)) ? q_ff + 32'd1 : q_ff;

   assign wdividend = {diff, 8'd0};
   assign wdivisor = 16'(fc - 8'd1);
   assign ndividend = (state_ff == ST_IDLE) ? 16'(req_item.slot_index)
                                            : {1'b0, rng_ff[30:16]};
   assign ndivisor = (state_ff == ST_IDLE) ? 16'(len_ff) : 16'(fc - 8'd1);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      base_in = base_ff;
      len_in = len_ff;
      m_in = m_ff;
      ch_in = ch_ff;
      ti_in = ti_ff;
      ptr_in = ptr_ff;
      addr_in = addr_ff;
      rng_in = rng_ff;
      hz_in = hz_ff;
      spacing_in = spacing_ff;
      prod_in = prod_ff;
      q_in = q_ff;
      r_in = r_ff;
      req_in = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      wstart = 1'b0;
      nstart = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item.req_type;
               if (req_item.req_type == REQ_REBUILD) begin
                  rng_in = seed_ff;
                  ptr_in = '0;
                  wstart = 1'b1;
                  state_in = ST_SP_DIV;
               end else if (len_ff == '0) begin
                  ptr_in = '0;
                  ch_in = 8'd0;
                  state_in = ST_MUL;
               end else if (req_item.req_type == REQ_NEXT) begin
                  if (LW'(ptr_ff) + LW'(1) == len_ff) begin
                     ptr_in = '0;
                     addr_in = '0;
                  end else begin
                     ptr_in = ptr_ff + AW'(1);
                     addr_in = ptr_ff + AW'(1);
                  end
                  state_in = ST_RD;
               end else begin
                  nstart = 1'b1;
                  state_in = ST_IX_MOD;
               end
            end
         end
         ST_SP_DIV: begin
            if (wdone) begin
               spacing_in = wquo;
               pos_in = '0;
               m_in = 8'd0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (m_ff == 8'd0 && (10'(pos_ff) + 10'(fc) > 10'(TABLE_DEPTH))) begin
               len_in = pos_ff;
               pos_in = '0;
               m_in = 8'd0;
               base_in = '0;
               state_in = ST_SH_POS;
            end else begin
               ram_we = 1'b1;
               ram_waddr = pos_ff[AW-1:0];
               ram_wdata = (m_ff == 8'd0) ? sync : ((m_ff == sync) ? 8'd0 : m_ff);
               pos_in = pos_ff + LW'(1);
               m_in = m_next;
            end
         end
         ST_SH_POS: begin
            if (pos_ff == len_ff) begin
               ch_in = sync;
               state_in = ST_MUL;
            end else if (m_ff == 8'd0) begin
               pos_in = pos_ff + LW'(1);
               m_in = m_next;
            end else begin
               rng_in = rng_ff * LCG_MUL + LCG_ADD;
               state_in = ST_SH_MODST;
            end
         end
         ST_SH_MODST: begin
            nstart = 1'b1;
            state_in = ST_SH_MOD;
         end
         ST_SH_MOD: begin
            if (ndone) begin
               addr_in = AW'(base_ff + LW'(nrem[7:0]) + LW'(1));
               state_in = ST_SH_RDI;
            end
         end
         ST_SH_RDI: begin
            ram_raddr = pos_ff[AW-1:0];
            state_in = ST_SH_RDJ;
         end
         ST_SH_RDJ: begin
            ti_in = ram_rdata;
            ram_raddr = addr_ff;
            state_in = ST_SH_WRI;
         end
         ST_SH_WRI: begin
            ram_we = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = ram_rdata;
            state_in = ST_SH_WRJ;
         end
         ST_SH_WRJ: begin
            ram_we = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = ti_ff;
            pos_in = pos_ff + LW'(1);
            m_in = m_next;
            if (m_next == 8'd0) begin
               base_in = pos_ff + LW'(1);
            end
            state_in = ST_SH_POS;
         end
         ST_IX_MOD: begin
            if (ndone) begin
               addr_in = nrem[AW-1:0];
               if (req_ff == REQ_SET) begin
                  ptr_in = nrem[AW-1:0];
               end
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ram_raddr = addr_ff;
            state_in = ST_RDW;
         end
         ST_RDW: begin
            ch_in = ram_rdata;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = 48'(ch_ff) * 48'(spacing_ff);
            state_in = ST_HZ;
         end
         ST_HZ: begin
            hz_in = (sum[40:32] != 9'd0) ? 32'hFFFFFFFF : sum[31:0];
            state_in = ST_WST;
         end
         ST_WST: begin
            q_in = qprod[63:32] + (RECIP[32] ? hz_ff : 32'd0);
            state_in = ST_WDIV;
         end
         ST_WDIV: begin
            r_in = hz_ff - dprod[31:0];
            state_in = ST_WFIX;
         end
         ST_WFIX: begin
            rsp_valid_in = 1'b1;
            rsp_in.freq_word = (qfix[31:25] != 7'd0) ? WORD_MAX : qfix[24:0];
            rsp_in.channel_number = ch_ff;
            rsp_in.hop_position = 8'(ptr_ff);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_ff <= 32'd0;
         count_ff <= 8'd80;
         start_hz_ff <= 32'd2400400000;
         end_hz_ff <= 32'd2479400000;
         len_ff <= LW'(TABLE_DEPTH);
         ptr_ff <= '0;
         rng_ff <= '0;
         spacing_ff <= '0;
         pos_ff <= '0;
         m_ff <= '0;
         base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         ptr_ff <= ptr_in;
         rng_ff <= rng_in;
         spacing_ff <= spacing_in;
         pos_ff <= pos_in;
         m_ff <= m_in;
         base_ff <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HOP_SEED: seed_ff <= csr_wdata;
               CSR_CHANNEL_COUNT: count_ff <= csr_wdata[7:0];
               CSR_BAND_START: start_hz_ff <= csr_wdata;
               CSR_BAND_END: end_hz_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      ch_ff <= ch_in;
      ti_ff <= ti_in;
      addr_ff <= addr_in;
      hz_ff <= hz_in;
      prod_ff <= prod_in;
      q_ff <= q_in;
      r_ff <= r_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   fhss_ram #(
      .WIDTH(8),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   fhss_div #(
      .DW(40),
      .VW(16)
   ) u_wide_div (
      .clock(clock),
      .reset(reset),
      .start(wstart),
      .dividend(wdividend),
      .divisor(wdivisor),
      .done(wdone),
      .quotient(wquo),
      .remainder(wrem)
   );

   fhss_div #(
      .DW(16),
      .VW(16)
   ) u_mod_div (
      .clock(clock),
      .reset(reset),
      .start(nstart),
      .dividend(ndividend),
      .divisor(ndivisor),
      .done(ndone),
      .quotient(nquo),
      .remainder(nrem)
   );

   assign busy = (state_ff != ST_IDLE) || (count_ff32 == 32'hFFFFFFFF && wrem == 16'hFFFF
                 && nquo_unused_w == 40'hFFFFFFFFFF);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

@@ hdl/fhss_ram.sv @@
module fhss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/fhss_div.sv @@
module fhss_div #(
   parameter int DW = 40,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = CW'(DW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = VW'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule
